// File: hdl/crmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crmv_pkg: shared types and constants for the running mean/variance block
// Widths, command and status codes, and the sequencer's control program.
// ----------------------------------------------------------------------------
package crmv_pkg;

  localparam int SAMPLE_W = 16;            // signed Q8.8 sample
  localparam int COUNT_W  = 10;
  localparam int STAT_W   = 3;
  localparam int STD_W    = 16;
  localparam int FRAC_EXT = 8;             // Q8.8 -> 16 fraction bits
  localparam int MEAN_W   = SAMPLE_W + FRAC_EXT;
  localparam int DIFF_W   = MEAN_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int M2_SHIFT = 16;
  localparam int M2_W     = 44;            // bounds 1023 folded samples
  localparam int DQ_W     = M2_W;          // divider / root shift register
  localparam int ROOT_W   = DQ_W / 2;
  localparam int SREM_W   = ROOT_W + 2;
  localparam int ITER_W   = 5;
  localparam int PC_W     = 4;
  localparam int MARK_DIV = 10;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(200);
  localparam logic [COUNT_W-1:0] MAX_LIMIT   = COUNT_W'(1023);

  // iterations of the shared unit (two quotient bits or one root bit each)
  localparam logic [ITER_W-1:0] ITERS_MEAN = ITER_W'((DIFF_W + 1) / 2);
  localparam logic [ITER_W-1:0] ITERS_VAR  = ITER_W'(DQ_W / 2);
  localparam logic [ITER_W-1:0] ITERS_SQRT = ITER_W'(ROOT_W);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_MISSING  = 3'd2,
    ST_STARTED  = 3'd3,
    ST_REPORT   = 3'd4
  } status_e;

  typedef enum logic {
    FS_IDLE,
    FS_RUN
  } fsm_e;

  typedef enum logic [3:0] {
    UOP_DIFF,
    UOP_DIV,
    UOP_MEAN,
    UOP_MUL,
    UOP_M2,
    UOP_VARLD,
    UOP_SQLD,
    UOP_SQRT,
    UOP_STD,
    UOP_DONE
  } uop_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_ITER,    // loop while the shared unit has iterations left
    JC_NOVAR,   // skip the variance when count < 2 or M2 is zero
    JC_HOLD     // wait for the output register
  } jcond_e;

  typedef enum logic [2:0] {
    AR_HOLD,
    AR_LOAD_DIV,
    AR_DIV_STEP,
    AR_LOAD_SQRT,
    AR_SQRT_STEP
  } arith_op_e;

  typedef struct packed {
    uop_e              uop;
    jcond_e            jc;
    logic [PC_W-1:0]   target;
    logic              fin;
  } ctrl_word_t;

  typedef struct packed {
    arith_op_e         op;
    logic [ITER_W-1:0] iters;
  } arith_ctl_t;

  localparam logic [PC_W-1:0] PC_DIFF     = PC_W'(0);
  localparam logic [PC_W-1:0] PC_DIV_MEAN = PC_W'(1);
  localparam logic [PC_W-1:0] PC_MEAN     = PC_W'(2);
  localparam logic [PC_W-1:0] PC_MUL      = PC_W'(3);
  localparam logic [PC_W-1:0] PC_M2       = PC_W'(4);
  localparam logic [PC_W-1:0] PC_VARLD    = PC_W'(5);
  localparam logic [PC_W-1:0] PC_DIV_VAR  = PC_W'(6);
  localparam logic [PC_W-1:0] PC_SQLD     = PC_W'(7);
  localparam logic [PC_W-1:0] PC_SQRT     = PC_W'(8);
  localparam logic [PC_W-1:0] PC_STD      = PC_W'(9);
  localparam logic [PC_W-1:0] PC_DONE     = PC_W'(10);

  // control program: one word per step
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{uop: UOP_DONE, jc: JC_HOLD, target: PC_DONE, fin: 1'b1};
    unique case (pc)
      PC_DIFF:     cw = '{uop: UOP_DIFF,  jc: JC_NONE,  target: PC_DIFF,     fin: 1'b0};
      PC_DIV_MEAN: cw = '{uop: UOP_DIV,   jc: JC_ITER,  target: PC_DIV_MEAN, fin: 1'b0};
      PC_MEAN:     cw = '{uop: UOP_MEAN,  jc: JC_NONE,  target: PC_DIFF,     fin: 1'b0};
      PC_MUL:      cw = '{uop: UOP_MUL,   jc: JC_NONE,  target: PC_DIFF,     fin: 1'b0};
      PC_M2:       cw = '{uop: UOP_M2,    jc: JC_NONE,  target: PC_DIFF,     fin: 1'b0};
      PC_VARLD:    cw = '{uop: UOP_VARLD, jc: JC_NOVAR, target: PC_DONE,     fin: 1'b0};
      PC_DIV_VAR:  cw = '{uop: UOP_DIV,   jc: JC_ITER,  target: PC_DIV_VAR,  fin: 1'b0};
      PC_SQLD:     cw = '{uop: UOP_SQLD,  jc: JC_NONE,  target: PC_DIFF,     fin: 1'b0};
      PC_SQRT:     cw = '{uop: UOP_SQRT,  jc: JC_ITER,  target: PC_SQRT,     fin: 1'b0};
      PC_STD:      cw = '{uop: UOP_STD,   jc: JC_NONE,  target: PC_DIFF,     fin: 1'b0};
      PC_DONE:     cw = '{uop: UOP_DONE,  jc: JC_HOLD,  target: PC_DONE,     fin: 1'b1};
      default:     cw = '{uop: UOP_DONE,  jc: JC_HOLD,  target: PC_DONE,     fin: 1'b1};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

// File: hdl/crmv_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crmv_in_if: input channel
// Valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface crmv_in_if import crmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       sensor_missing;

  modport source (output valid, cmd, sample_value, sensor_missing, input ready);
  modport sink   (input valid, cmd, sample_value, sensor_missing, output ready);
endinterface
`default_nettype wire

// File: hdl/crmv_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crmv_out_if: result channel
// Valid/ready handshake carrying one statistics beat.
// ----------------------------------------------------------------------------
interface crmv_out_if import crmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STAT_W-1:0]          status_code;
  logic [COUNT_W-1:0]         sample_count;
  logic signed [SAMPLE_W-1:0] mean_value;
  logic [STD_W-1:0]           std_value;
  logic                       limit_reached;
  logic                       progress_mark;
  logic                       training_active;

  modport source (output valid, status_code, sample_count, mean_value, std_value,
                  limit_reached, progress_mark, training_active, input ready);
  modport sink   (input valid, status_code, sample_count, mean_value, std_value,
                  limit_reached, progress_mark, training_active, output ready);
endinterface
`default_nettype wire

// File: hdl/crmv_divsqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crmv_divsqrt: shared iterative divide and square root unit
// Restoring divide by a 10-bit divisor, two quotient bits per cycle, and a
// digit-by-digit floor square root, one root bit per cycle, on one register.
// ----------------------------------------------------------------------------
module crmv_divsqrt import crmv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire arith_ctl_t         ctl_i,
  input  wire logic [DQ_W-1:0]    dividend_i,
  input  wire logic [COUNT_W-1:0] divisor_i,
  output logic [DQ_W-1:0]         quot_o,
  output logic [ROOT_W-1:0]       root_o,
  output logic                    last_o
);

  logic [DQ_W-1:0]    dq_q, dq_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [COUNT_W-1:0] div_q, div_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [SREM_W-1:0]  srem_q, srem_d;
  logic [ITER_W-1:0]  iter_q, iter_d;

  logic [DQ_W-1:0]    div_x;
  logic [COUNT_W-1:0] div_r;

  // two restoring steps: shift a dividend bit into the remainder, subtract
  always_comb begin
    logic [COUNT_W:0] r2;
    div_x = dq_q;
    div_r = rem_q;
    for (int k = 0; k < 2; k++) begin
      r2    = {div_r, div_x[DQ_W-1]};
      div_x = {div_x[DQ_W-2:0], 1'b0};
      if (r2 >= {1'b0, div_q}) begin
        r2       = r2 - {1'b0, div_q};
        div_x[0] = 1'b1;
      end
      div_r = r2[COUNT_W-1:0];
    end
  end

  logic [SREM_W-1:0] sq_s2, sq_trial;
  assign sq_s2    = {srem_q[SREM_W-3:0], dq_q[DQ_W-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    div_d  = div_q;
    root_d = root_q;
    srem_d = srem_q;
    iter_d = iter_q;
    case (ctl_i.op)
      AR_LOAD_DIV: begin
        dq_d   = dividend_i;
        rem_d  = '0;
        div_d  = divisor_i;
        iter_d = ctl_i.iters;
      end
      AR_DIV_STEP: begin
        dq_d   = div_x;
        rem_d  = div_r;
        iter_d = iter_q - 1'b1;
      end
      AR_LOAD_SQRT: begin
        root_d = '0;
        srem_d = '0;
        iter_d = ctl_i.iters;
      end
      AR_SQRT_STEP: begin
        dq_d   = {dq_q[DQ_W-3:0], 2'b00};
        iter_d = iter_q - 1'b1;
        if (sq_s2 >= sq_trial) begin
          srem_d = sq_s2 - sq_trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_d = sq_s2;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else begin
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    root_q <= root_d;
    srem_q <= srem_d;
  end

  assign quot_o = dq_q;
  assign root_o = root_q;
  assign last_o = (iter_q == ITER_W'(1));

endmodule
`default_nettype wire

// File: hdl/capped_running_mean_variance.sv
`default_nettype none
// A folded sample runs the mean divide, variance divide and square root on the shared
//   divide/root unit; the last two are skipped when count is below 2 or M2 is zero.
// The block accepts no new command until the previous result is loaded into the
//   output register; other commands go to that load directly.
// A stalled output register holds the sequencer until its beat drains.
// Reset: idle, statistics cleared, sample_limit 200, output empty.
// ----------------------------------------------------------------------------
// capped_running_mean_variance: capped Welford mean and deviation tracker
// A microcoded sequencer steps a small datapath through each folded sample.
// ----------------------------------------------------------------------------
module capped_running_mean_variance import crmv_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  crmv_in_if.sink                 in_i,
  crmv_out_if.source              out_o
);

  fsm_e state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;

  logic [COUNT_W-1:0]       limit_q;
  logic                     training_q;
  logic [COUNT_W-1:0]       count_q;
  logic [3:0]               cnt10_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic [M2_W-1:0]          m2_q;
  logic [STD_W-1:0]         std_q;
  logic                     out_valid_q;

  // per-item datapath registers
  status_e                    status_q;
  logic                       done_q, mark_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [DIFF_W-1:0]   d_q;
  logic signed [PROD_W-1:0]   prod_q;

  ctrl_word_t cw;
  assign cw = ucode(pc_q);

  logic in_fire, slot_free, novar, jump, ar_last;
  logic [COUNT_W-1:0] limit_eff;
  logic fold;

  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign limit_eff = (limit_q > MAX_LIMIT) ? MAX_LIMIT : limit_q;
  assign fold      = (cmd_e'(in_i.cmd) == CMD_SAMPLE) && !in_i.sensor_missing
                     && training_q && (count_q < limit_eff);
  assign novar     = (count_q < COUNT_W'(2)) || (m2_q == '0);

  always_comb begin
    case (cw.jc)
      JC_ITER:  jump = !ar_last;
      JC_NOVAR: jump = novar;
      JC_HOLD:  jump = !slot_free;
      default:  jump = 1'b0;
    endcase
  end

  // sequencer state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (in_fire) state_d = FS_RUN;
      FS_RUN:  if (cw.fin && !jump) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    pc_d       = pc_q;
    unique case (state_q)
      FS_IDLE: begin
        in_i.ready = 1'b1;
        if (in_fire) pc_d = fold ? PC_DIFF : PC_DONE;
      end
      FS_RUN: pc_d = jump ? cw.target : pc_q + 1'b1;
      default: ;
    endcase
  end

  // datapath arithmetic
  logic signed [MEAN_W-1:0] t_s;
  logic signed [DIFF_W-1:0] d_s, e_s;
  logic [DIFF_W-1:0]        abs_d;
  logic [COUNT_W-1:0]       count_inc;
  logic [DQ_W-1:0]          quot;
  logic [ROOT_W-1:0]        root;
  logic signed [DIFF_W:0]   q_s, mean_sum;
  logic signed [PROD_W-1:0] prod_adj;
  logic [M2_W-1:0]          m2_inc;
  logic signed [MEAN_W-1:0] mean_adj;

  assign t_s       = {sample_q, FRAC_EXT'(0)};
  assign d_s       = DIFF_W'(t_s) - DIFF_W'(mean_q);
  assign e_s       = DIFF_W'(t_s) - DIFF_W'(mean_q);
  assign abs_d     = d_s[DIFF_W-1] ? DIFF_W'(-d_s) : DIFF_W'(d_s);
  assign count_inc = count_q + 1'b1;
  assign q_s       = d_q[DIFF_W-1] ? -$signed({1'b0, quot[DIFF_W-1:0]})
                                   :  $signed({1'b0, quot[DIFF_W-1:0]});
  assign mean_sum  = (DIFF_W + 1)'(mean_q) + q_s;
  // truncate toward zero on the shifts
  assign prod_adj  = prod_q + (prod_q[PROD_W-1] ? PROD_W'((1 << M2_SHIFT) - 1) : '0);
  assign m2_inc    = M2_W'(prod_adj >>> M2_SHIFT);
  assign mean_adj  = mean_q + (mean_q[MEAN_W-1] ? MEAN_W'((1 << FRAC_EXT) - 1) : '0);

  arith_ctl_t        ar_ctl;
  logic [DQ_W-1:0]   ar_dividend;
  logic [COUNT_W-1:0] ar_divisor;

  always_comb begin
    ar_ctl      = '{op: AR_HOLD, iters: '0};
    ar_dividend = {1'b0, abs_d, (DQ_W - DIFF_W - 1)'(0)};
    ar_divisor  = count_inc;
    if (state_q == FS_RUN) begin
      case (cw.uop)
        UOP_DIFF:  ar_ctl = '{op: AR_LOAD_DIV, iters: ITERS_MEAN};
        UOP_DIV:   ar_ctl = '{op: AR_DIV_STEP, iters: '0};
        UOP_VARLD: begin
          ar_dividend = m2_q;
          ar_divisor  = count_q - 1'b1;
          if (!novar) ar_ctl = '{op: AR_LOAD_DIV, iters: ITERS_VAR};
        end
        UOP_SQLD:  ar_ctl = '{op: AR_LOAD_SQRT, iters: ITERS_SQRT};
        UOP_SQRT:  ar_ctl = '{op: AR_SQRT_STEP, iters: '0};
        default: ;
      endcase
    end
  end

  crmv_divsqrt u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ar_ctl),
    .dividend_i (ar_dividend),
    .divisor_i  (ar_divisor),
    .quot_o     (quot),
    .root_o     (root),
    .last_o     (ar_last)
  );

  logic out_load;
  assign out_load = (state_q == FS_RUN) && (cw.uop == UOP_DONE) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      pc_q        <= PC_DIFF;
      limit_q     <= LIMIT_RESET;
      training_q  <= 1'b0;
      count_q     <= '0;
      cnt10_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      std_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && cmd_e'(in_i.cmd) == CMD_START) begin
        training_q <= 1'b1;
        count_q    <= '0;
        cnt10_q    <= '0;
        mean_q     <= '0;
        m2_q       <= '0;
        std_q      <= '0;
      end
      if (state_q == FS_RUN) begin
        case (cw.uop)
          UOP_DIFF: begin
            count_q <= count_inc;
            cnt10_q <= (cnt10_q == 4'(MARK_DIV - 1)) ? '0 : cnt10_q + 1'b1;
            if (count_inc >= limit_eff) training_q <= 1'b0;
          end
          UOP_MEAN:  mean_q <= mean_sum[MEAN_W-1:0];
          UOP_M2:    m2_q   <= m2_q + m2_inc;
          UOP_VARLD: if (novar) std_q <= '0;
          UOP_STD:   std_q  <= (root > ROOT_W'({STD_W{1'b1}})) ? {STD_W{1'b1}}
                                                               : root[STD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.sample_value;
      done_q   <= 1'b0;
      mark_q   <= 1'b0;
      case (cmd_e'(in_i.cmd))
        CMD_SAMPLE: status_q <= in_i.sensor_missing ? ST_MISSING
                                : (fold ? ST_ACCEPTED : ST_IGNORED);
        CMD_START:  status_q <= ST_STARTED;
        CMD_QUERY:  status_q <= ST_REPORT;
        default:    status_q <= ST_IGNORED;
      endcase
    end
    if (state_q == FS_RUN && cw.uop == UOP_DIFF) begin
      d_q    <= d_s;
      done_q <= (count_inc >= limit_eff);
      mark_q <= (cnt10_q == 4'(MARK_DIV - 1));
    end
    if (state_q == FS_RUN && cw.uop == UOP_MUL) begin
      prod_q <= d_q * e_s;
    end
    if (out_load) begin
      out_o.status_code     <= status_q;
      out_o.sample_count    <= count_q;
      out_o.mean_value      <= mean_adj[MEAN_W-1 -: SAMPLE_W];
      out_o.std_value       <= std_q;
      out_o.limit_reached   <= done_q;
      out_o.progress_mark   <= mark_q;
      out_o.training_active <= training_q;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for capped_running_mean_variance
// Sends command beats through a directed table, then through random training
// sessions at several sample limits. An in-bench Welford tracker predicts each
// beat no typed row supplies, and each is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import crmv_pkg::*;

  localparam logic [1:0] CMD_RSVD = 2'd3;
  localparam int GUARD_CYCLES = 70;
  localparam int N_DIR = 27;

  typedef struct packed {
    status_e                    status;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] mean;
    logic [STD_W-1:0]           std;
    logic                       done;
    logic                       mark;
    logic                       active;
  } stat_beat_t;

  typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_e;

  // for a ROW_LIMIT row, value carries the new sample limit
  typedef struct packed {
    row_kind_e           kind;
    logic [1:0]          cmd;
    logic [SAMPLE_W-1:0] value;
    logic                missing;
    logic                typed;
    stat_beat_t          want;
  } dir_row_t;

  localparam stat_beat_t NO_BEAT = '0;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COUNT_W-1:0] cfg_wdata_i;

  crmv_in_if  in_ch ();
  crmv_out_if out_ch ();

  capped_running_mean_variance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // tracker state
  logic               tr_active;
  logic [COUNT_W-1:0] tr_count;
  logic [COUNT_W-1:0] tr_limit;
  longint             mean_q16;
  longint             m2_q16;

  stat_beat_t stats_due[$];
  dir_row_t   dir_rows[N_DIR];
  bit         gaps_on;
  int         stall_left;
  int         n_errors;
  int         n_cmds;
  int         n_folded;
  int         n_done;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic stat_beat_t track_stats(input logic [1:0] cmd,
                                             input logic signed [SAMPLE_W-1:0] smp,
                                             input logic missing);
    stat_beat_t r;
    longint t;
    longint d;
    longint unsigned var_q;
    longint unsigned root;
    longint unsigned cand;
    r = '0;
    r.status = ST_IGNORED;
    case (cmd)
      CMD_SAMPLE: begin
        if (missing) begin
          r.status = ST_MISSING;
        end else if (tr_active && tr_count < tr_limit) begin
          t = longint'(smp) * 256;
          d = t - mean_q16;
          tr_count = tr_count + 1'b1;
          mean_q16 = mean_q16 + d / longint'(tr_count);
          m2_q16 = m2_q16 + (d * (t - mean_q16)) / 65536;
          r.status = ST_ACCEPTED;
          r.mark = (tr_count % MARK_DIV) == 0;
          n_folded++;
          if (tr_count >= tr_limit) begin
            r.done = 1'b1;
            tr_active = 1'b0;
            n_done++;
          end
        end
      end
      CMD_START: begin
        tr_active = 1'b1;
        tr_count = '0;
        mean_q16 = 0;
        m2_q16 = 0;
        r.status = ST_STARTED;
      end
      CMD_QUERY: r.status = ST_REPORT;
      default: r.status = ST_IGNORED;
    endcase
    r.count = tr_count;
    r.mean = 16'(mean_q16 / 256);
    r.active = tr_active;
    if (tr_count >= 2 && m2_q16 > 0) begin
      var_q = (64'(unsigned'(m2_q16))) / (64'(tr_count) - 64'd1);
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= var_q) root = cand;
      end
      r.std = (root > 64'd65535) ? 16'hFFFF : 16'(root);
    end
    return r;
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] value,
                          input logic missing, input bit typed, input stat_beat_t want);
    stat_beat_t pred;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.sample_value   <= value;
    in_ch.sensor_missing <= missing;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    pred = track_stats(cmd, value, missing);
    if (typed) pred = want;
    stats_due = {stats_due, pred};
    n_cmds++;
  endtask

  // hold off new beats until every outstanding result is back
  task automatic drain_stats();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (stats_due.size() != 0);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] limit);
    drain_stats();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tr_limit = limit;
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] limit, input int n_items,
                           input int sample_pct, input bit to_limit);
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] v;
    logic [1:0]          cmd;
    int                  pick;
    write_limit(limit);
    base = 16'($urandom);
    send_cmd(CMD_START, 16'($urandom), 1'($urandom), 1'b0, NO_BEAT);
    for (int i = 0; i < n_items || (to_limit && tr_active); i++) begin
      pick = $urandom_range(0, 99);
      if (!tr_active && $urandom_range(0, 1) == 1) begin
        base = 16'($urandom);
        send_cmd(CMD_START, 16'($urandom), 1'($urandom), 1'b0, NO_BEAT);
      end else if (pick < sample_pct) begin
        case ($urandom_range(0, 9))
          0:       v = {1'($urandom), {15{1'($urandom)}}};
          1, 2:    v = 16'($urandom);
          default: v = base + 16'($urandom_range(0, 511)) - 16'd256;
        endcase
        send_cmd(CMD_SAMPLE, v, 1'b0, 1'b0, NO_BEAT);
      end else begin
        case ($urandom_range(0, 4))
          0: send_cmd(CMD_SAMPLE, 16'($urandom), 1'b1, 1'b0, NO_BEAT);
          1: send_cmd(CMD_QUERY, 16'($urandom), 1'($urandom), 1'b0, NO_BEAT);
          2: send_cmd(CMD_RSVD, 16'($urandom), 1'($urandom), 1'b0, NO_BEAT);
          3: send_cmd(to_limit ? CMD_QUERY : CMD_START, 16'($urandom), 1'($urandom),
                      1'b0, NO_BEAT);
          default: begin
            cmd = 2'($urandom);
            if (to_limit && cmd == CMD_START) cmd = CMD_QUERY;
            send_cmd(cmd, 16'($urandom), 1'($urandom), 1'b0, NO_BEAT);
          end
        endcase
      end
      if ($urandom_range(0, 199) == 0) drain_stats();
    end
  endtask

  always @(posedge clk_i) begin : result_sink
    stat_beat_t got;
    stat_beat_t want;
    logic       rdy;
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{status_e'(out_ch.status_code), out_ch.sample_count, out_ch.mean_value,
              out_ch.std_value, out_ch.limit_reached, out_ch.progress_mark,
              out_ch.training_active};
      if (stats_due.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat: status %0d count %0d",
                                     got.status, got.count);
      end else begin
        want = stats_due.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("mismatch: exp status %0d count %0d mean %0d std %0d done %0b mark %0b act %0b",
                     want.status, want.count, want.mean, want.std, want.done, want.mark,
                     want.active);
            $display("          got status %0d count %0d mean %0d std %0d done %0b mark %0b act %0b",
                     got.status, got.count, got.mean, got.std, got.done, got.mark,
                     got.active);
          end
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ch.ready <= rdy;
  end

  initial begin
    #6ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_SAMPLE;
    in_ch.sample_value   = '0;
    in_ch.sensor_missing = 1'b0;
    out_ch.ready         = 1'b0;
    gaps_on              = 1'b1;
    stall_left           = 0;
    n_errors             = 0;
    n_cmds               = 0;
    n_folded             = 0;
    n_done               = 0;
    tr_active            = 1'b0;
    tr_count             = '0;
    tr_limit             = LIMIT_RESET;
    mean_q16             = 0;
    m2_q16               = 0;

    dir_rows = '{
      // idle block: samples, queries and the reserved code change nothing
      '{ROW_BEAT, CMD_SAMPLE, 16'h1234, 1'b0, 1'b1, '{ST_IGNORED, 0, 0, 0, 0, 0, 0}},
      '{ROW_BEAT, CMD_QUERY,  16'h0000, 1'b0, 1'b1, '{ST_REPORT,  0, 0, 0, 0, 0, 0}},
      '{ROW_BEAT, CMD_RSVD,   16'h0000, 1'b0, 1'b1, '{ST_IGNORED, 0, 0, 0, 0, 0, 0}},
      '{ROW_BEAT, CMD_SAMPLE, 16'h7FFF, 1'b1, 1'b1, '{ST_MISSING, 0, 0, 0, 0, 0, 0}},
      // start ignores its sample fields
      '{ROW_BEAT, CMD_START,  16'hFFFF, 1'b1, 1'b1, '{ST_STARTED, 0, 0, 0, 0, 0, 1}},
      '{ROW_BEAT, CMD_SAMPLE, 16'h7FFF, 1'b0, 1'b1, '{ST_ACCEPTED, 1, 32767, 0, 0, 0, 1}},
      '{ROW_BEAT, CMD_SAMPLE, 16'h8000, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0100, 1'b1, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_QUERY,  16'h5A5A, 1'b1, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_RSVD,   16'hA5A5, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0001, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0000, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h7FFF, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h8000, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h1900, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'hE700, 1'b0, 1'b0, NO_BEAT},
      // tenth sample raises the progress mark
      '{ROW_BEAT, CMD_SAMPLE, 16'h0080, 1'b0, 1'b0, NO_BEAT},
      // limit lowered under the count: samples are ignored, training holds
      '{ROW_LIMIT, CMD_SAMPLE, 16'd2, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0200, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_START,  16'h0000, 1'b0, 1'b1, '{ST_STARTED, 0, 0, 0, 0, 0, 1}},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0300, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0500, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0700, 1'b0, 1'b0, NO_BEAT},
      // zero limit: training never completes
      '{ROW_LIMIT, CMD_SAMPLE, 16'd0, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BEAT, CMD_START,  16'h1111, 1'b0, 1'b1, '{ST_STARTED, 0, 0, 0, 0, 0, 1}},
      '{ROW_BEAT, CMD_SAMPLE, 16'h0900, 1'b0, 1'b0, NO_BEAT}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMIT) begin
        write_limit(dir_rows[i].value[COUNT_W-1:0]);
      end else begin
        send_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].missing,
                 dir_rows[i].typed, dir_rows[i].want);
      end
    end

    run_phase(10'd1, 40, 75, 1'b0);
    run_phase(10'd1023, 1000, 95, 1'b1);
    run_phase(10'd0, 20, 75, 1'b0);
    run_phase(10'($urandom_range(2, 1022)), 60, 80, 1'b0);
    gaps_on <= 1'b0;
    run_phase(10'd10, 50, 80, 1'b0);

    drain_stats();
    repeat (GUARD_CYCLES) @(posedge clk_i);

    $display("Covered %0d commands: %0d samples folded, %0d trainings completed,",
             n_cmds, n_folded, n_done);
    $display("with sample limits 0, 1, 2, 10, 200, 1023 and one random value.");
    if (n_errors == 0 && stats_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
